>>> rtl/slab_alloc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slab_alloc_pkg
// shared types, codes and constants of the slab object allocator
// ----------------------------------------------------------------------------
package slab_alloc_pkg;

  localparam int ADDR_W  = 32;
  localparam int OBJ_W   = 12;
  localparam int CNT_W   = 10;
  localparam int LINK_W  = 11;
  localparam int SLOT_W  = 10;
  localparam int DIV_W   = 16;

  localparam logic [CNT_W-1:0]  OBJ_CAP  = 10'd1023;
  localparam logic [LINK_W-1:0] NO_LINK  = 11'd2047;
  localparam logic [OBJ_W-1:0]  OBJ_MIN  = 12'd4;
  localparam logic [OBJ_W-1:0]  OBJ_RST  = 12'd16;

  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 12;
  localparam int MAX_SLABS_DEF    = 16;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_NO_SLAB    = 2'd2,
    ST_MISALIGNED = 2'd3
  } status_t;

  localparam logic CFG_OBJ_BYTES = 1'b0;
  localparam logic CFG_POOL_BASE = 1'b1;

  typedef struct packed {
    op_e_t             op;
    logic [ADDR_W-1:0] addr;
  } item_t;

  typedef struct packed {
    logic              changed;
    logic [OBJ_W-1:0]  object_bytes;
    logic [ADDR_W-1:0] pool_base;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [OBJ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [OBJ_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/slab_alloc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slab_alloc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module slab_alloc_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire slab_alloc_pkg::div_req_t  req,
  output slab_alloc_pkg::div_rsp_t       rsp
);
  import slab_alloc_pkg::*;

  logic [OBJ_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [OBJ_W-1:0] dvs_r, dvs_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [OBJ_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DIV_W-1]};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = OBJ_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[OBJ_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

>>> rtl/slab_alloc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slab_alloc_front
// accepts requests, decodes the operation and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module slab_alloc_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [31:0]            in_tdata,
  input  wire logic [1:0]             in_tuser,
  output logic                        q_valid,
  output slab_alloc_pkg::item_t       q_item,
  input  wire logic                   q_pop
);
  import slab_alloc_pkg::*;

  item_t      ent0_r, ent0_nxt, ent1_r, ent1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      new_item;

  assign in_tready     = (cnt_r != 2'd2);
  assign push          = in_tvalid && in_tready;
  assign new_item.op   = op_e_t'(in_tuser);
  assign new_item.addr = in_tdata;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    cnt_nxt  = cnt_r;
    if (q_pop && cnt_r != 2'd0) begin
      ent0_nxt = ent1_r;
      cnt_nxt  = cnt_nxt - 2'd1;
    end
    if (push) begin
      if (cnt_nxt == 2'd0) ent0_nxt = new_item;
      else                 ent1_nxt = new_item;
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent0_r;

endmodule
`default_nettype wire

>>> rtl/slab_alloc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slab_alloc_back
// executes allocate, free and clear against the slab table and link memory
// ----------------------------------------------------------------------------
module slab_alloc_back #(
  parameter int PAGE_BYTES   = slab_alloc_pkg::PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = slab_alloc_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SLABS    = slab_alloc_pkg::MAX_SLABS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire slab_alloc_pkg::cfg_t     cfg,
  input  wire logic                     q_valid,
  input  wire slab_alloc_pkg::item_t    q_item,
  output logic                          q_pop,
  output slab_alloc_pkg::div_req_t      div_req,
  input  wire slab_alloc_pkg::div_rsp_t div_rsp,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [47:0]                   out_tdata,
  output logic [1:0]                    out_tuser
);
  import slab_alloc_pkg::*;

  localparam int SLAB_W  = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int NSL_W   = $clog2(MAX_SLABS + 1);
  localparam int LA_W    = SLAB_W + SLOT_W;
  localparam int SENT_W  = LINK_W + CNT_W;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_NDIV  = 12'b0000_0000_0010,
    S_ARD   = 12'b0000_0000_0100,
    S_ACHK  = 12'b0000_0000_1000,
    S_ALNK  = 12'b0000_0001_0000,
    S_ANEW  = 12'b0000_0010_0000,
    S_FILL  = 12'b0000_0100_0000,
    S_OADDR = 12'b0000_1000_0000,
    S_OSUM  = 12'b0001_0000_0000,
    S_FOFF  = 12'b0010_0000_0000,
    S_FDIV  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t              st_r, st_nxt;
  logic                need_n_r, need_n_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [NSL_W-1:0]    slabs_r, slabs_nxt;
  logic [SLAB_W-1:0]   k_r, k_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [21:0]         prod_r, prod_nxt;
  logic [ADDR_W-1:0]   pg_r, pg_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  status_t             res_st_r, res_st_nxt;
  logic [CNT_W-1:0]    res_cnt_r, res_cnt_nxt;
  logic                ov_r, ov_nxt;
  logic [ADDR_W-1:0]   oa_r, oa_nxt;
  status_t             os_r, os_nxt;
  logic [CNT_W-1:0]    oc_r, oc_nxt;

  // slab table: free-list head and in-use count per slab
  logic [SENT_W-1:0]   smem [MAX_SLABS];
  logic [SENT_W-1:0]   sm_rd_r;
  logic                sm_we;
  logic [SENT_W-1:0]   sm_wd;
  logic [LINK_W-1:0]   sd_fh;
  logic [CNT_W-1:0]    sd_used;

  // per-object free links
  logic [LINK_W-1:0]   lmem [MAX_SLABS * 1024];
  logic [LINK_W-1:0]   lk_rd_r;
  logic [LA_W-1:0]     lk_ra, lk_wa;
  logic                lk_we;
  logic [LINK_W-1:0]   lk_wd;

  logic [OBJ_W-1:0]    obj_sz;
  logic [ADDR_W-1:0]   page_k;
  logic [ADDR_W-1:0]   off;
  logic [CNT_W-1:0]    used_inc, used_dec;

  assign obj_sz   = (cfg.object_bytes < OBJ_MIN) ? OBJ_MIN : cfg.object_bytes;
  assign page_k   = cfg.pool_base + ADDR_W'(k_r) * ADDR_W'(PAGE_BYTES);
  assign off      = addr_r - page_k;
  assign sd_fh    = sm_rd_r[SENT_W-1:CNT_W];
  assign sd_used  = sm_rd_r[CNT_W-1:0];
  assign used_inc = (sd_used < OBJ_CAP) ? sd_used + 10'd1 : sd_used;
  assign used_dec = (sd_used != '0) ? sd_used - 10'd1 : sd_used;
  assign lk_ra    = {k_r, sd_fh[SLOT_W-1:0]};

  always_comb begin
    st_nxt      = st_r;
    need_n_nxt  = need_n_r | cfg.changed;
    n_nxt       = n_r;
    slabs_nxt   = slabs_r;
    k_nxt       = k_r;
    idx_nxt     = idx_r;
    addr_nxt    = addr_r;
    prod_nxt    = prod_r;
    pg_nxt      = pg_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt  = res_st_r;
    res_cnt_nxt = res_cnt_r;
    ov_nxt      = ov_r;
    oa_nxt      = oa_r;
    os_nxt      = os_r;
    oc_nxt      = oc_r;
    q_pop       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(PAGE_BYTES - HEADER_BYTES);
    div_req.divisor  = obj_sz;
    sm_we = 1'b0;
    sm_wd = '0;
    lk_we = 1'b0;
    lk_wa = {k_r, idx_r};
    lk_wd = NO_LINK;

    if (ov_r && out_tready) ov_nxt = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (need_n_r) begin
          div_req.start = 1'b1;
          need_n_nxt    = cfg.changed;
          st_nxt        = S_NDIV;
        end else if (q_valid) begin
          q_pop       = 1'b1;
          addr_nxt    = q_item.addr;
          res_addr_nxt = '0;
          res_st_nxt  = ST_OK;
          res_cnt_nxt = '0;
          k_nxt       = SLAB_W'(slabs_r - NSL_W'(1));
          unique case (q_item.op)
            OP_ALLOC: st_nxt = (slabs_r == '0) ? S_ANEW : S_ARD;
            OP_FREE: begin
              if (slabs_r == '0) begin
                res_st_nxt = ST_NO_SLAB;
                st_nxt     = S_OUT;
              end else begin
                st_nxt = S_FOFF;
              end
            end
            OP_CLEAR: begin
              slabs_nxt = '0;
              st_nxt    = S_OUT;
            end
            default: st_nxt = S_OUT;
          endcase
        end
      end
      S_NDIV: begin
        if (div_rsp.done) begin
          n_nxt  = (div_rsp.quo > DIV_W'(OBJ_CAP)) ? OBJ_CAP : div_rsp.quo[CNT_W-1:0];
          st_nxt = S_IDLE;
        end
      end
      S_ARD: st_nxt = S_ACHK;
      S_ACHK: begin
        if (sd_fh != NO_LINK) begin
          idx_nxt = sd_fh[SLOT_W-1:0];
          st_nxt  = S_ALNK;
        end else if (k_r == '0) begin
          st_nxt = S_ANEW;
        end else begin
          k_nxt  = k_r - SLAB_W'(1);
          st_nxt = S_ARD;
        end
      end
      S_ALNK: begin
        sm_we       = 1'b1;
        sm_wd       = {lk_rd_r, used_inc};
        res_cnt_nxt = used_inc;
        st_nxt      = S_OADDR;
      end
      S_ANEW: begin
        if (slabs_r >= NSL_W'(MAX_SLABS) || n_r == '0) begin
          res_st_nxt = ST_EXHAUSTED;
          st_nxt     = S_OUT;
        end else begin
          k_nxt     = SLAB_W'(slabs_r);
          slabs_nxt = slabs_r + NSL_W'(1);
          idx_nxt   = '0;
          st_nxt    = S_FILL;
        end
      end
      S_FILL: begin
        // thread objects lowest-first, idx_r walks the slots
        lk_we = 1'b1;
        lk_wd = ((idx_r + 10'd1) < n_r) ? LINK_W'(idx_r + 10'd1) : NO_LINK;
        if (idx_r == n_r - 10'd1) begin
          sm_we       = 1'b1;
          sm_wd       = {(n_r > 10'd1) ? LINK_W'(1) : NO_LINK, CNT_W'(1)};
          res_cnt_nxt = CNT_W'(1);
          idx_nxt     = '0;
          st_nxt      = S_OADDR;
        end else begin
          idx_nxt = idx_r + 10'd1;
        end
      end
      S_OADDR: begin
        prod_nxt = idx_r * obj_sz;
        pg_nxt   = page_k;
        st_nxt   = S_OSUM;
      end
      S_OSUM: begin
        res_addr_nxt = pg_r + ADDR_W'(HEADER_BYTES) + ADDR_W'(prod_r);
        st_nxt       = S_OUT;
      end
      S_FOFF: begin
        if (off < ADDR_W'(PAGE_BYTES) && off >= ADDR_W'(HEADER_BYTES)) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(off - ADDR_W'(HEADER_BYTES));
          st_nxt           = S_FDIV;
        end else if (k_r == '0) begin
          res_st_nxt = ST_NO_SLAB;
          st_nxt     = S_OUT;
        end else begin
          k_nxt = k_r - SLAB_W'(1);
        end
      end
      S_FDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != '0 || div_rsp.quo >= DIV_W'(n_r)) begin
            res_st_nxt = ST_MISALIGNED;
          end else begin
            lk_we       = 1'b1;
            lk_wa       = {k_r, div_rsp.quo[SLOT_W-1:0]};
            lk_wd       = sd_fh;
            sm_we       = 1'b1;
            sm_wd       = {LINK_W'(div_rsp.quo[SLOT_W-1:0]), used_dec};
            res_cnt_nxt = used_dec;
          end
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          oa_nxt = res_addr_r;
          os_nxt = res_st_r;
          oc_nxt = res_cnt_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sm_we) smem[k_r] <= sm_wd;
    sm_rd_r <= smem[k_r];
    if (lk_we) lmem[lk_wa] <= lk_wd;
    lk_rd_r <= lmem[lk_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      need_n_r <= 1'b1;
      slabs_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      need_n_r <= need_n_nxt;
      slabs_r  <= slabs_nxt;
      ov_r     <= ov_nxt;
    end
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    idx_r      <= idx_nxt;
    addr_r     <= addr_nxt;
    prod_r     <= prod_nxt;
    pg_r       <= pg_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    res_cnt_r  <= res_cnt_nxt;
    oa_r       <= oa_nxt;
    os_r       <= os_nxt;
    oc_r       <= oc_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'b0, oc_r, oa_r};
  assign out_tuser  = os_r;

endmodule
`default_nettype wire

>>> rtl/slab_object_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slab_object_allocator_top
// fixed-size object allocator over a pool of contiguous pages
// ----------------------------------------------------------------------------
// channel  direction  contents
// in_      slave      tdata: object_address[31:0]; tuser: operation[1:0]
// out_     master     tdata: result_address[31:0], in_use_count[41:32]
//                     tuser: status[1:0]
// cfg_     write      index 0 object_bytes, index 1 pool_base
//
// one item at a time; a request queue of two entries sits in front.
// allocate scans the slabs from the newest down for a free object; a new
// slab first threads its free list. free checks the slabs in the same order,
// then runs the 16-step offset division. clear drops all slabs.
// after reset and after every config write the objects-per-slab count is
// recomputed by the divider before the next item starts.
// a held result stalls only the back end; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module slab_object_allocator_top #(
  parameter int PAGE_BYTES   = slab_alloc_pkg::PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = slab_alloc_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SLABS    = slab_alloc_pkg::MAX_SLABS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // object_address
  input  wire logic [1:0]  in_tuser,   // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // result_address, in_use_count, zero fill
  output logic [1:0]       out_tuser,  // status
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import slab_alloc_pkg::*;

  logic [OBJ_W-1:0]  obj_bytes_r, obj_bytes_nxt;
  logic [ADDR_W-1:0] pool_base_r, pool_base_nxt;
  logic              chg_r;
  cfg_t              cfg;
  logic              q_valid, q_pop;
  item_t             q_item;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  always_comb begin
    obj_bytes_nxt = obj_bytes_r;
    pool_base_nxt = pool_base_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OBJ_BYTES: obj_bytes_nxt = cfg_wdata[OBJ_W-1:0];
        CFG_POOL_BASE: pool_base_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_bytes_r <= OBJ_RST;
      pool_base_r <= '0;
      chg_r       <= 1'b0;
    end else begin
      obj_bytes_r <= obj_bytes_nxt;
      pool_base_r <= pool_base_nxt;
      chg_r       <= cfg_wr_en;
    end
  end

  assign cfg.changed      = chg_r;
  assign cfg.object_bytes = obj_bytes_r;
  assign cfg.pool_base    = pool_base_r;

  slab_alloc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  slab_alloc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  slab_alloc_back #(
    .PAGE_BYTES   (PAGE_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_SLABS    (MAX_SLABS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

>>> tb/sv/tb_slab_object_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slab_object_allocator_top
// checks allocate, free and clear results of the slab allocator against an
// in-bench allocator model, over directed rows, random traffic and settings
// ----------------------------------------------------------------------------
module tb_slab_object_allocator_top;
  import slab_alloc_pkg::*;

  localparam int PAGE = 4096;
  localparam int HDR = 12;
  localparam int NSLAB = 16;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] addr;
    status_t     status;
    logic [9:0]  count;
  } alloc_result_t;

  typedef struct {
    op_e_t         op;
    logic [31:0]   addr;
    logic          known;
    alloc_result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [31:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tready = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;
  wire in_tready, out_tvalid;
  wire [47:0] out_tdata;
  wire [1:0] out_tuser;

  slab_object_allocator_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // allocator model state
  logic [11:0] m_obj_bytes;
  logic [31:0] m_base;
  int unsigned m_slabs;
  int unsigned m_head [NSLAB];
  int unsigned m_used [NSLAB];
  int unsigned m_link [NSLAB*1024];

  alloc_result_t pending_results[$];
  row_t rows[$];
  int errors = 0;
  int idle_cycles = 0;
  logic stall_out = 1'b0;

  function automatic int unsigned obj_sz();
    return (m_obj_bytes < 4) ? 4 : m_obj_bytes;
  endfunction

  function automatic int unsigned per_slab();
    int unsigned n;
    n = (PAGE - HDR) / obj_sz();
    return n > 1023 ? 1023 : n;
  endfunction

  function automatic logic [31:0] page_of(int unsigned s);
    return m_base + 32'(s * PAGE);
  endfunction

  function automatic alloc_result_t predict_alloc_op(op_e_t op, logic [31:0] a);
    alloc_result_t r;
    int unsigned n, idx, k;
    logic [31:0] off, rel;
    r = '{32'd0, ST_OK, 10'd0};
    if (op == OP_ALLOC) begin
      for (int s = m_slabs; s > 0; s--) begin
        k = s - 1;
        if (m_head[k] != NO_LINK) begin
          idx = m_head[k] & 1023;
          m_head[k] = m_link[k*1024 + idx];
          if (m_used[k] < 1023) m_used[k]++;
          return '{page_of(k) + HDR + 32'(idx * obj_sz()), ST_OK, 10'(m_used[k])};
        end
      end
      n = per_slab();
      if (m_slabs >= NSLAB || n == 0) return '{32'd0, ST_EXHAUSTED, 10'd0};
      k = m_slabs++;
      for (int i = 0; i < n; i++) m_link[k*1024 + i] = (i + 1 < n) ? i + 1 : NO_LINK;
      m_head[k] = m_link[k*1024];
      m_used[k] = 1;
      return '{page_of(k) + HDR, ST_OK, 10'd1};
    end else if (op == OP_FREE) begin
      n = per_slab();
      for (int s = m_slabs; s > 0; s--) begin
        k = s - 1;
        off = a - page_of(k);
        if (off >= PAGE || off < HDR) continue;
        rel = off - HDR;
        idx = rel / obj_sz();
        if (rel % obj_sz() != 0 || idx >= n) return '{32'd0, ST_MISALIGNED, 10'd0};
        m_link[k*1024 + idx] = m_head[k];
        m_head[k] = idx;
        if (m_used[k] > 0) m_used[k]--;
        return '{32'd0, ST_OK, 10'(m_used[k])};
      end
      return '{32'd0, ST_NO_SLAB, 10'd0};
    end else if (op == OP_CLEAR) begin
      m_slabs = 0;
    end
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_OBJ_BYTES) m_obj_bytes = v[11:0];
    else m_base = v;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // one transfer into the block; a random gap follows some items
  task automatic send_item(op_e_t op, logic [31:0] a, logic known, alloc_result_t exp_r);
    alloc_result_t p;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= a;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = predict_alloc_op(op, a);
    if (known && p != exp_r) begin
      $error("directed row disagrees with model: %h vs %h", exp_r, p);
      errors++;
    end
    pending_results.push_back(p);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // address mostly near live objects so frees hit real slabs
  function automatic logic [31:0] pick_free_addr();
    int unsigned s, i;
    if (m_slabs == 0 || $urandom_range(0, 9) == 0) return $urandom();
    s = $urandom_range(0, m_slabs - 1);
    i = $urandom_range(0, per_slab() - 1);
    case ($urandom_range(0, 5))
      0: return page_of(s) + $urandom_range(0, HDR - 1);
      1: return page_of(s) + HDR + 32'(i * obj_sz()) + $urandom_range(1, 3);
      2: return page_of(s) + $urandom_range(PAGE - 8, PAGE - 1);
      default: return page_of(s) + HDR + 32'(i * obj_sz());
    endcase
  endfunction

  task automatic random_phase(int count);
    op_e_t op;
    int r;
    for (int j = 0; j < count; j++) begin
      r = $urandom_range(0, 99);
      op = r < 55 ? OP_ALLOC : r < 95 ? OP_FREE : r < 98 ? OP_CLEAR : OP_NOP;
      send_item(op, op == OP_FREE ? pick_free_addr() : $urandom(), 1'b0, '0);
    end
    stop_sending();
  endtask

  // result checking
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[31:0] !== e.addr) begin
          $error("result_address exp %h got %h", e.addr, out_tdata[31:0]);
          errors++;
        end
        if (out_tuser !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_tuser);
          errors++;
        end
        if (out_tdata[41:32] !== e.count) begin
          $error("in_use_count exp %0d got %0d", e.count, out_tdata[41:32]);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern: quiet stretches and choppy ones
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_out <= ~stall_out;
    out_tready <= stall_out ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL slab_object_allocator_top");
      $finish;
    end
  end

  initial begin
    m_obj_bytes = 12'd16;
    m_base = 32'd0;
    m_slabs = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at reset settings (object 16, base 0)
    rows.push_back('{OP_FREE, 32'd12, 1'b1, '{32'd0, ST_NO_SLAB, 10'd0}});
    rows.push_back('{OP_ALLOC, 32'hFFFF_FFFF, 1'b1, '{32'd12, ST_OK, 10'd1}});
    rows.push_back('{OP_ALLOC, 32'd0, 1'b1, '{32'd28, ST_OK, 10'd2}});
    rows.push_back('{OP_FREE, 32'd4, 1'b1, '{32'd0, ST_NO_SLAB, 10'd0}});
    rows.push_back('{OP_FREE, 32'd13, 1'b1, '{32'd0, ST_MISALIGNED, 10'd0}});
    rows.push_back('{OP_FREE, 32'd4095, 1'b1, '{32'd0, ST_MISALIGNED, 10'd0}});
    rows.push_back('{OP_FREE, 32'd12, 1'b1, '{32'd0, ST_OK, 10'd1}});
    rows.push_back('{OP_FREE, 32'd12, 1'b1, '{32'd0, ST_OK, 10'd0}});
    rows.push_back('{OP_FREE, 32'd28, 1'b1, '{32'd0, ST_OK, 10'd0}});
    rows.push_back('{OP_ALLOC, 32'd0, 1'b0, '0});
    rows.push_back('{OP_ALLOC, 32'd0, 1'b0, '0});
    rows.push_back('{OP_NOP, 32'hFFFF_FFFF, 1'b1, '{32'd0, ST_OK, 10'd0}});
    rows.push_back('{OP_FREE, 32'h8000_0000, 1'b1, '{32'd0, ST_NO_SLAB, 10'd0}});
    rows.push_back('{OP_CLEAR, 32'd0, 1'b1, '{32'd0, ST_OK, 10'd0}});
    rows.push_back('{OP_FREE, 32'd28, 1'b1, '{32'd0, ST_NO_SLAB, 10'd0}});
    rows.push_back('{OP_ALLOC, 32'd0, 1'b1, '{32'd12, ST_OK, 10'd1}});
    foreach (rows[i]) send_item(rows[i].op, rows[i].addr, rows[i].known, rows[i].res);
    stop_sending();
    // hold off until every result is back
    drain();

    // object too large for a page, top of pool base range
    write_reg(CFG_OBJ_BYTES, 32'd4095);
    write_reg(CFG_POOL_BASE, 32'hFFFF_F000);
    send_item(OP_CLEAR, 32'd0, 1'b1, '{32'd0, ST_OK, 10'd0});
    send_item(OP_ALLOC, 32'd0, 1'b1, '{32'd0, ST_EXHAUSTED, 10'd0});
    stop_sending();
    drain();
    write_reg(CFG_OBJ_BYTES, 32'd2042);
    send_item(OP_ALLOC, 32'd0, 1'b0, '0);
    stop_sending();
    drain();

    // large objects: pool runs dry quickly
    write_reg(CFG_OBJ_BYTES, 32'd2000);
    write_reg(CFG_POOL_BASE, 32'h1234_5000);
    send_item(OP_CLEAR, 32'd0, 1'b0, '0);
    random_phase(120);
    drain();

    // minimum size, below-minimum value acts as four
    write_reg(CFG_OBJ_BYTES, 32'd0);
    write_reg(CFG_POOL_BASE, 32'hFFFF_8000);
    send_item(OP_CLEAR, 32'd0, 1'b0, '0);
    send_item(OP_ALLOC, 32'd0, 1'b0, '0);
    random_phase(60);
    drain();

    write_reg(CFG_OBJ_BYTES, 32'd4);
    write_reg(CFG_POOL_BASE, 32'd0);
    random_phase(60);
    drain();

    // mid sizes, random bases
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_OBJ_BYTES, $urandom_range(300, 1500));
      write_reg(CFG_POOL_BASE, {$urandom_range(0, 20'hFFFFF), 12'h000});
      send_item(OP_CLEAR, 32'd0, 1'b0, '0);
      random_phase(100);
      drain();
    end

    if (errors == 0) begin
      $display("PASS slab_object_allocator_top");
    end else begin
      $display("FAIL slab_object_allocator_top");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/slab_alloc_pkg.sv
rtl/slab_alloc_div.sv
rtl/slab_alloc_front.sv
rtl/slab_alloc_back.sv
rtl/slab_object_allocator_top.sv
tb/sv/tb_slab_object_allocator_top.sv
